/* design/scc_pkg.sv */
package scc_pkg;

  // access commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_DROP  = 2'd3;

  localparam int SECTOR_W = 32;

  // control flags carried by every ring cell
  typedef struct packed {
    logic valid;
    logic dirty;
    logic accessed;
  } cell_flags_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOOK = 5'b00010,
    ST_SRCH = 5'b00100,
    ST_FLSH = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

endpackage

/* design/scc_cell.sv */
module scc_cell #(
  parameter int SW = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic                       clr,
  input  scc_pkg::cell_flags_t       d_flags,
  input  logic [scc_pkg::SECTOR_W-1:0] d_sector,
  input  logic [SW-1:0]              d_slot,
  output scc_pkg::cell_flags_t       q_flags,
  output logic [scc_pkg::SECTOR_W-1:0] q_sector,
  output logic [SW-1:0]              q_slot
);

  scc_pkg::cell_flags_t                flags_r;
  logic [scc_pkg::SECTOR_W-1:0]        sector_r;
  logic [SW-1:0]                       slot_r;

  // flags are control state, cleared by reset and by a drop
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      flags_r <= '0;
    end else if (shift_en) begin
      flags_r <= d_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sector_r <= d_sector;
      slot_r   <= d_slot;
    end
  end

  assign q_flags  = flags_r;
  assign q_sector = sector_r;
  assign q_slot   = slot_r;

endmodule

/* design/sector_cache_clock_replacement_unit.sv */
// Tag and second-chance replacement unit for a fully associative sector cache.
// The cache entries live in a ring of ENTRIES cells that rotates by one cell
// per cycle during a lookup, scan or flush unless a flush result is held up;
// the cell at the head is the only one examined. A read or write transaction
// walks the whole ring in lookup (a hit or a fill into a free slot is settled
// within that rotation), then posts its result and returns to idle to take
// the next item. A miss with every slot in use adds a clock scan: the scan
// clears accessed marks as it passes and, once it meets the victim, closes
// the gap and appends the new entry while finishing the lap. A flush walks
// the ring once and emits one result per dirty entry, or a single empty
// result if none is dirty; a drop clears the ring and posts its result
// without a walk. Results leave through an output register, so a full
// result register holds up only the final post of a transaction and a flush
// that has a further result to post. The rate is set by the single head
// comparator walked around the ring.
module sector_cache_clock_replacement_unit #(
  parameter int ENTRIES      = 64,
  parameter int SECTOR_BYTES = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [31:0]                 in_sector_number,
  input  logic [8:0]                  in_byte_offset,
  input  logic [9:0]                  in_byte_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [$clog2(ENTRIES)-1:0]  out_slot,
  output logic                        out_evicted,
  output logic                        out_writeback,
  output logic [31:0]                 out_writeback_sector,
  output logic                        out_fill_from_device,
  output logic                        out_zero_fill,
  output logic                        out_last
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [SW-1:0] K_LAST = SW'(ENTRIES - 1);

  // ring cells, index 0 is the head
  scc_pkg::cell_flags_t          c_flags  [ENTRIES];
  logic [31:0]                   c_sector [ENTRIES];
  logic [SW-1:0]                 c_slot   [ENTRIES];

  // value fed into the tail cell this cycle
  scc_pkg::cell_flags_t          feed_flags;
  logic [31:0]                   feed_sector;
  logic [SW-1:0]                 feed_slot;

  logic                          shift_en;
  logic                          cells_clr;

  scc_pkg::state_t               state_r, state_nxt;
  logic [SW-1:0]                 k_r, k_nxt;          // ring position at the head
  logic [1:0]                    cmd_r, cmd_nxt;
  logic [31:0]                   sec_r, sec_nxt;
  logic                          zero_r, zero_nxt;    // whole-sector write
  logic                          hit_r, hit_nxt;
  logic [SW-1:0]                 hslot_r, hslot_nxt;
  logic                          armed_r, armed_nxt;  // clock scan under way
  logic                          compact_r, compact_nxt;
  logic [SW-1:0]                 vslot_r, vslot_nxt;
  logic [31:0]                   vsec_r, vsec_nxt;
  logic                          vdirty_r, vdirty_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [SW-1:0]                 clock_r, clock_nxt;
  logic                          unset_r, unset_nxt;

  // pending flush result, posted once the next one (or the end) is known
  logic                          pend_r, pend_nxt;
  logic [SW-1:0]                 pslot_r, pslot_nxt;
  logic [31:0]                   psec_r, psec_nxt;

  // result staged for the final post
  logic                          rhit_r, rhit_nxt;
  logic [SW-1:0]                 rslot_r, rslot_nxt;
  logic                          rev_r, rev_nxt;
  logic                          rwb_r, rwb_nxt;
  logic [31:0]                   rwsec_r, rwsec_nxt;
  logic                          rfill_r, rfill_nxt;
  logic                          rzero_r, rzero_nxt;

  // output register
  logic                          ovalid_r, ovalid_nxt;
  logic                          ohit_r, ohit_nxt;
  logic [SW-1:0]                 oslot_r, oslot_nxt;
  logic                          oev_r, oev_nxt;
  logic                          owb_r, owb_nxt;
  logic [31:0]                   owsec_r, owsec_nxt;
  logic                          ofill_r, ofill_nxt;
  logic                          ozero_r, ozero_nxt;
  logic                          olast_r, olast_nxt;

  logic                          in_fire;
  logic                          out_free;
  logic                          k_last;
  logic [SW-1:0]                 scan_start;
  logic                          head_match;
  logic                          armed_now;
  logic                          flush_hit;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      scc_cell #(.SW(SW)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .clr      (cells_clr),
        .d_flags  ((gi == ENTRIES - 1) ? feed_flags  : c_flags[(gi + 1) % ENTRIES]),
        .d_sector ((gi == ENTRIES - 1) ? feed_sector : c_sector[(gi + 1) % ENTRIES]),
        .d_slot   ((gi == ENTRIES - 1) ? feed_slot   : c_slot[(gi + 1) % ENTRIES]),
        .q_flags  (c_flags[gi]),
        .q_sector (c_sector[gi]),
        .q_slot   (c_slot[gi])
      );
    end
  endgenerate

  assign in_ready = (state_r == scc_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !ovalid_r || out_ready;
  assign k_last   = (k_r == K_LAST);

  // clock scan starts one past the clock, or at the ring front if never placed
  assign scan_start = (unset_r || clock_r == K_LAST) ? '0 : SW'(clock_r + 1'b1);
  assign head_match = c_flags[0].valid && (c_sector[0] == sec_r);
  assign armed_now  = armed_r || (k_r == scan_start);
  assign flush_hit  = c_flags[0].valid && c_flags[0].dirty;

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    cmd_nxt     = cmd_r;
    sec_nxt     = sec_r;
    zero_nxt    = zero_r;
    hit_nxt     = hit_r;
    hslot_nxt   = hslot_r;
    armed_nxt   = armed_r;
    compact_nxt = compact_r;
    vslot_nxt   = vslot_r;
    vsec_nxt    = vsec_r;
    vdirty_nxt  = vdirty_r;
    count_nxt   = count_r;
    clock_nxt   = clock_r;
    unset_nxt   = unset_r;
    pend_nxt    = pend_r;
    pslot_nxt   = pslot_r;
    psec_nxt    = psec_r;
    rhit_nxt    = rhit_r;
    rslot_nxt   = rslot_r;
    rev_nxt     = rev_r;
    rwb_nxt     = rwb_r;
    rwsec_nxt   = rwsec_r;
    rfill_nxt   = rfill_r;
    rzero_nxt   = rzero_r;
    ovalid_nxt  = ovalid_r && !out_ready;
    ohit_nxt    = ohit_r;
    oslot_nxt   = oslot_r;
    oev_nxt     = oev_r;
    owb_nxt     = owb_r;
    owsec_nxt   = owsec_r;
    ofill_nxt   = ofill_r;
    ozero_nxt   = ozero_r;
    olast_nxt   = olast_r;

    // by default the head goes round to the tail unchanged
    feed_flags  = c_flags[0];
    feed_sector = c_sector[0];
    feed_slot   = c_slot[0];
    shift_en    = 1'b0;
    cells_clr   = 1'b0;

    case (state_r)
      scc_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt     = in_cmd;
          sec_nxt     = in_sector_number;
          zero_nxt    = (in_cmd == scc_pkg::CMD_WRITE) && (in_byte_offset == '0) &&
                        (32'(in_byte_count) >= 32'(SECTOR_BYTES));
          k_nxt       = '0;
          hit_nxt     = 1'b0;
          armed_nxt   = 1'b0;
          compact_nxt = 1'b0;
          pend_nxt    = 1'b0;
          // staged result defaults to the empty one
          rhit_nxt    = 1'b0;
          rslot_nxt   = '0;
          rev_nxt     = 1'b0;
          rwb_nxt     = 1'b0;
          rwsec_nxt   = '0;
          rfill_nxt   = 1'b0;
          rzero_nxt   = 1'b0;
          case (in_cmd)
            scc_pkg::CMD_DROP: begin
              // forget everything, dirty entries included
              cells_clr = 1'b1;
              count_nxt = '0;
              clock_nxt = '0;
              unset_nxt = 1'b1;
              state_nxt = scc_pkg::ST_RESP;
            end
            scc_pkg::CMD_FLUSH: state_nxt = scc_pkg::ST_FLSH;
            default:            state_nxt = scc_pkg::ST_LOOK;
          endcase
        end
      end

      scc_pkg::ST_LOOK: begin
        shift_en = 1'b1;
        k_nxt    = k_last ? '0 : SW'(k_r + 1'b1);
        if (head_match && !hit_r) begin
          feed_flags.accessed = 1'b1;
          if (cmd_r == scc_pkg::CMD_WRITE) begin
            feed_flags.dirty = 1'b1;
          end
          hit_nxt   = 1'b1;
          hslot_nxt = c_slot[0];
        end else if (!hit_r && CW'(k_r) == count_r) begin
          // first free ring position: the new entry takes slot count
          feed_flags.valid    = 1'b1;
          feed_flags.dirty    = (cmd_r == scc_pkg::CMD_WRITE);
          feed_flags.accessed = 1'b0;
          feed_sector         = sec_r;
          feed_slot           = count_r[SW-1:0];
        end
        if (k_last) begin
          if (hit_r || head_match) begin
            rhit_nxt  = 1'b1;
            rslot_nxt = hit_r ? hslot_r : c_slot[0];
            state_nxt = scc_pkg::ST_RESP;
          end else if (count_r != CW'(ENTRIES)) begin
            rslot_nxt = count_r[SW-1:0];
            rfill_nxt = !zero_r;
            rzero_nxt = zero_r;
            count_nxt = CW'(count_r + 1'b1);
            state_nxt = scc_pkg::ST_RESP;
          end else begin
            state_nxt = scc_pkg::ST_SRCH;
          end
        end
      end

      scc_pkg::ST_SRCH: begin
        shift_en = 1'b1;
        k_nxt    = k_last ? '0 : SW'(k_r + 1'b1);
        if (compact_r) begin
          // victim gone: each later entry moves up one ring position
          feed_flags  = c_flags[1 % ENTRIES];
          feed_sector = c_sector[1 % ENTRIES];
          feed_slot   = c_slot[1 % ENTRIES];
        end else if (armed_now && c_flags[0].accessed) begin
          // second chance
          feed_flags.accessed = 1'b0;
          armed_nxt           = 1'b1;
        end else if (armed_now) begin
          compact_nxt = 1'b1;
          vslot_nxt   = c_slot[0];
          vsec_nxt    = c_sector[0];
          vdirty_nxt  = c_flags[0].dirty;
          clock_nxt   = k_last ? '0 : k_r;
          unset_nxt   = 1'b0;
          feed_flags  = c_flags[1 % ENTRIES];
          feed_sector = c_sector[1 % ENTRIES];
          feed_slot   = c_slot[1 % ENTRIES];
        end
        if (k_last && (compact_r || armed_now && !c_flags[0].accessed)) begin
          // append the new entry at the ring tail in the victim's slot
          feed_flags.valid    = 1'b1;
          feed_flags.dirty    = (cmd_r == scc_pkg::CMD_WRITE);
          feed_flags.accessed = 1'b0;
          feed_sector         = sec_r;
          feed_slot           = compact_r ? vslot_r : c_slot[0];
          rslot_nxt           = feed_slot;
          rev_nxt             = 1'b1;
          rwb_nxt             = compact_r ? vdirty_r : c_flags[0].dirty;
          rwsec_nxt           = rwb_nxt ? (compact_r ? vsec_r : c_sector[0]) : '0;
          rfill_nxt           = !zero_r;
          rzero_nxt           = zero_r;
          state_nxt           = scc_pkg::ST_RESP;
        end
      end

      scc_pkg::ST_FLSH: begin
        // a second dirty entry has to wait for room in the output register
        if (!(flush_hit && pend_r && !out_free)) begin
          shift_en = 1'b1;
          k_nxt    = k_last ? '0 : SW'(k_r + 1'b1);
          if (flush_hit) begin
            feed_flags.dirty = 1'b0;
            if (pend_r) begin
              ovalid_nxt = 1'b1;
              ohit_nxt   = 1'b0;
              oslot_nxt  = pslot_r;
              oev_nxt    = 1'b0;
              owb_nxt    = 1'b1;
              owsec_nxt  = psec_r;
              ofill_nxt  = 1'b0;
              ozero_nxt  = 1'b0;
              olast_nxt  = 1'b0;
            end
            pend_nxt  = 1'b1;
            pslot_nxt = c_slot[0];
            psec_nxt  = c_sector[0];
          end
          if (k_last) begin
            // the newest dirty entry, if any, becomes the last result
            rslot_nxt = pend_nxt ? pslot_nxt : '0;
            rwb_nxt   = pend_nxt;
            rwsec_nxt = pend_nxt ? psec_nxt : '0;
            state_nxt = scc_pkg::ST_RESP;
          end
        end
      end

      scc_pkg::ST_RESP: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ohit_nxt   = rhit_r;
          oslot_nxt  = rslot_r;
          oev_nxt    = rev_r;
          owb_nxt    = rwb_r;
          owsec_nxt  = rwsec_r;
          ofill_nxt  = rfill_r;
          ozero_nxt  = rzero_r;
          olast_nxt  = 1'b1;
          state_nxt  = scc_pkg::ST_IDLE;
        end
      end

      default: state_nxt = scc_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= scc_pkg::ST_IDLE;
      k_r       <= '0;
      hit_r     <= 1'b0;
      armed_r   <= 1'b0;
      compact_r <= 1'b0;
      count_r   <= '0;
      clock_r   <= '0;
      unset_r   <= 1'b1;
      pend_r    <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      hit_r     <= hit_nxt;
      armed_r   <= armed_nxt;
      compact_r <= compact_nxt;
      count_r   <= count_nxt;
      clock_r   <= clock_nxt;
      unset_r   <= unset_nxt;
      pend_r    <= pend_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    sec_r    <= sec_nxt;
    zero_r   <= zero_nxt;
    hslot_r  <= hslot_nxt;
    vslot_r  <= vslot_nxt;
    vsec_r   <= vsec_nxt;
    vdirty_r <= vdirty_nxt;
    pslot_r  <= pslot_nxt;
    psec_r   <= psec_nxt;
    rhit_r   <= rhit_nxt;
    rslot_r  <= rslot_nxt;
    rev_r    <= rev_nxt;
    rwb_r    <= rwb_nxt;
    rwsec_r  <= rwsec_nxt;
    rfill_r  <= rfill_nxt;
    rzero_r  <= rzero_nxt;
    ohit_r   <= ohit_nxt;
    oslot_r  <= oslot_nxt;
    oev_r    <= oev_nxt;
    owb_r    <= owb_nxt;
    owsec_r  <= owsec_nxt;
    ofill_r  <= ofill_nxt;
    ozero_r  <= ozero_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid            = ovalid_r;
  assign out_hit              = ohit_r;
  assign out_slot             = oslot_r;
  assign out_evicted          = oev_r;
  assign out_writeback        = owb_r;
  assign out_writeback_sector = owsec_r;
  assign out_fill_from_device = ofill_r;
  assign out_zero_fill        = ozero_r;
  assign out_last             = olast_r;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count beyond capacity");

  a_resp_posts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scc_pkg::ST_RESP && out_free) |=> (ovalid_r && olast_r))
    else $error("final result not posted");

  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == scc_pkg::CMD_DROP) |=> (count_r == '0 && unset_r))
    else $error("drop left entries behind");

  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scc_pkg::ST_SRCH) |-> (count_r == CW'(ENTRIES)))
    else $error("clock scan with free slots");
`endif

endmodule

/* tb/sv/sector_cache_clock_replacement_unit_tb.sv */
module sector_cache_clock_replacement_unit_tb;

  localparam int NSLOT = 64;
  localparam int SLOT_W = $clog2(NSLOT);
  localparam int SECTOR_SIZE = 512;
  localparam int RANDOM_ITEMS = 260;

  // one result transaction, field for field
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic              writeback;
    logic [31:0]       writeback_sector;
    logic              fill_from_device;
    logic              zero_fill;
    logic              last;
  } cache_result_t;

  // directed stimulus row, with an optional hand-written expectation
  typedef struct {
    logic [1:0]    cmd;
    logic [31:0]   sector;
    logic [8:0]    offset;
    logic [9:0]    count;
    bit            typed;
    cache_result_t want;
  } access_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_cmd;
  logic [31:0] in_sector_number;
  logic [8:0] in_byte_offset;
  logic [9:0] in_byte_count;
  logic out_valid;
  logic out_ready;
  logic out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic out_evicted;
  logic out_writeback;
  logic [31:0] out_writeback_sector;
  logic out_fill_from_device;
  logic out_zero_fill;
  logic out_last;

  sector_cache_clock_replacement_unit #(
    .ENTRIES(NSLOT),
    .SECTOR_BYTES(SECTOR_SIZE)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_sector_number(in_sector_number),
    .in_byte_offset(in_byte_offset),
    .in_byte_count(in_byte_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_hit(out_hit),
    .out_slot(out_slot),
    .out_evicted(out_evicted),
    .out_writeback(out_writeback),
    .out_writeback_sector(out_writeback_sector),
    .out_fill_from_device(out_fill_from_device),
    .out_zero_fill(out_zero_fill),
    .out_last(out_last)
  );

  // mirror of the cache tags and the clock ring
  logic [31:0] tag_sector[NSLOT];
  bit          tag_dirty[NSLOT];
  bit          tag_accessed[NSLOT];
  int          ring_slot[NSLOT];
  int          live_count;
  int          hand_pos;
  bit          hand_unplaced;

  cache_result_t pending_results[$];
  int mismatch_count = 0;

  // directed rows carry their own expectation here
  cache_result_t typed_override;
  bit            use_typed;

  // idling knobs, percent of cycles
  int sender_idle_pct;
  int receiver_stall_pct;
  bit long_hold_req;
  bit hold_done;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // a run that never finishes is a failure
  initial begin
    #(20 * 1500000);
    $display("status: fail");
    $finish;
  end

  function automatic cache_result_t make_result(bit hit, int slot, bit ev, bit wb,
                                                logic [31:0] wsec, bit fill, bit zero,
                                                bit last);
    cache_result_t r;
    r.hit = hit;
    r.slot = slot[SLOT_W-1:0];
    r.evicted = ev;
    r.writeback = wb;
    r.writeback_sector = wsec;
    r.fill_from_device = fill;
    r.zero_fill = zero;
    r.last = last;
    return r;
  endfunction

  function automatic void clear_tags();
    for (int i = 0; i < NSLOT; i++) begin
      tag_dirty[i] = 0;
      tag_accessed[i] = 0;
      ring_slot[i] = 0;
    end
    live_count = 0;
    hand_pos = 0;
    hand_unplaced = 1;
  endfunction

  // the clock hand steps around the ring, wrapping past the tail
  function automatic void step_hand();
    if (hand_unplaced || hand_pos + 1 >= live_count) hand_pos = 0;
    else hand_pos++;
    hand_unplaced = 0;
  endfunction

  // second chance scan: clear accessed marks until an unmarked victim turns up,
  // then close the ring gap and leave the hand on the victim's successor
  function automatic int pick_victim(output logic [31:0] vsec, output bit vdirty);
    int s;
    int p;
    step_hand();
    s = ring_slot[hand_pos];
    while (tag_accessed[s]) begin
      tag_accessed[s] = 0;
      step_hand();
      s = ring_slot[hand_pos];
    end
    vsec = tag_sector[s];
    vdirty = tag_dirty[s];
    tag_dirty[s] = 0;
    p = hand_pos;
    for (int i = p; i + 1 < live_count; i++) ring_slot[i] = ring_slot[i + 1];
    live_count--;
    hand_pos = (p < live_count) ? p : 0;
    return s;
  endfunction

  // works out the results of one accepted transaction and queues them
  function automatic void predict_access(logic [1:0] cmd, logic [31:0] sector,
                                         logic [8:0] offset, logic [9:0] count);
    cache_result_t r[$];
    int s;
    bit ev;
    bit vdirty;
    logic [31:0] vsec;
    bit zero;
    bit found;
    found = 0;
    ev = 0;
    vdirty = 0;
    vsec = '0;
    case (cmd)
      scc_pkg::CMD_FLUSH: begin
        // every dirty entry in ring order, cleaned as it goes
        for (int i = 0; i < live_count; i++) begin
          s = ring_slot[i];
          if (tag_dirty[s]) begin
            tag_dirty[s] = 0;
            r.push_back(make_result(0, s, 0, 1, tag_sector[s], 0, 0, 0));
          end
        end
        if (r.size() == 0) r.push_back(make_result(0, 0, 0, 0, '0, 0, 0, 1));
        else r[r.size() - 1].last = 1;
      end
      scc_pkg::CMD_DROP: begin
        clear_tags();
        r.push_back(make_result(0, 0, 0, 0, '0, 0, 0, 1));
      end
      default: begin
        for (int i = 0; i < live_count && !found; i++) begin
          s = ring_slot[i];
          if (tag_sector[s] == sector) begin
            tag_accessed[s] = 1;
            if (cmd == scc_pkg::CMD_WRITE) tag_dirty[s] = 1;
            r.push_back(make_result(1, s, 0, 0, '0, 0, 0, 1));
            found = 1;
          end
        end
        if (!found) begin
          if (live_count >= NSLOT) begin
            s = pick_victim(vsec, vdirty);
            ev = 1;
          end else begin
            s = live_count;
          end
          ring_slot[live_count] = s;
          live_count++;
          tag_sector[s] = sector;
          tag_accessed[s] = 0;
          tag_dirty[s] = (cmd == scc_pkg::CMD_WRITE);
          // whole-sector write needs no device read
          zero = (cmd == scc_pkg::CMD_WRITE) && offset == 0 && count >= SECTOR_SIZE;
          r.push_back(make_result(0, s, ev, vdirty, vdirty ? vsec : 32'h0, !zero, zero, 1));
        end
      end
    endcase
    if (use_typed) r[0] = typed_override;
    foreach (r[i]) pending_results.push_back(r[i]);
  endfunction

  // input acceptance feeds the predictor; output acceptance is checked
  always @(posedge clk) begin
    cache_result_t got;
    cache_result_t want;
    if (!rst_n) clear_tags();
    if (rst_n && in_valid && in_ready)
      predict_access(in_cmd, in_sector_number, in_byte_offset, in_byte_count);
    if (rst_n && out_valid && out_ready) begin
      got = make_result(out_hit, out_slot, out_evicted, out_writeback,
                        out_writeback_sector, out_fill_from_device, out_zero_fill, out_last);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("result mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold that lets the block back up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (long_hold_req && !hold_done) begin
      hold_cycles <= 600;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // offer one transaction and hold it until taken
  task automatic offer_access(logic [1:0] cmd, logic [31:0] sector,
                              logic [8:0] offset, logic [9:0] count);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_sector_number <= sector;
    in_byte_offset <= offset;
    in_byte_count <= count;
    do @(posedge clk); while (!in_ready);
    // sender gaps between transactions
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    // let the last accepted transaction reach the predictor first
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  access_row_t directed[$];

  function automatic void add_row(logic [1:0] cmd, logic [31:0] sector, logic [8:0] offset,
                                  logic [9:0] count, bit typed, cache_result_t want);
    access_row_t a;
    a.cmd = cmd;
    a.sector = sector;
    a.offset = offset;
    a.count = count;
    a.typed = typed;
    a.want = want;
    directed.push_back(a);
  endfunction

  // sectors mostly from a modest pool so hits and evictions both happen
  function automatic logic [31:0] pick_sector();
    int r;
    r = $urandom_range(99);
    if (r < 82) return ($urandom_range(109) * 32'h0101_0101) ^ 32'h5A5A_0000;
    if (r < 92) return $urandom;
    if (r < 96) return 32'h0;
    return 32'hFFFF_FFFF;
  endfunction

  initial begin
    cache_result_t none;
    cache_result_t empty_last;
    int r;
    int phase;
    logic [1:0] cmd;
    none = '0;
    empty_last = make_result(0, 0, 0, 0, '0, 0, 0, 1);
    use_typed = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    long_hold_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = scc_pkg::CMD_READ;
    in_sector_number = '0;
    in_byte_offset = '0;
    in_byte_count = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cache misses, whole-sector writes, partial writes,
    // flush with and without dirty entries, drop, hits
    add_row(scc_pkg::CMD_READ, 32'h0, 9'd0, 10'd512, 1,
            make_result(0, 0, 0, 0, 0, 1, 0, 1));
    add_row(scc_pkg::CMD_WRITE, 32'hFFFF_FFFF, 9'd0, 10'd512, 1,
            make_result(0, 1, 0, 0, 0, 0, 1, 1));
    add_row(scc_pkg::CMD_READ, 32'h0, 9'd511, 10'd0, 1,
            make_result(1, 0, 0, 0, 0, 0, 0, 1));
    add_row(scc_pkg::CMD_FLUSH, 32'h0, 9'd0, 10'd0, 1,
            make_result(0, 1, 0, 1, 32'hFFFF_FFFF, 0, 0, 1));
    add_row(scc_pkg::CMD_FLUSH, 32'h1234_5678, 9'd3, 10'd7, 1, empty_last);
    add_row(scc_pkg::CMD_WRITE, 32'h5, 9'd1, 10'd512, 1,
            make_result(0, 2, 0, 0, 0, 1, 0, 1));
    // counts past a sector saturate to a whole-sector write
    add_row(scc_pkg::CMD_WRITE, 32'h6, 9'd0, 10'd1023, 1,
            make_result(0, 3, 0, 0, 0, 0, 1, 1));
    add_row(scc_pkg::CMD_WRITE, 32'h7, 9'd0, 10'd511, 1,
            make_result(0, 4, 0, 0, 0, 1, 0, 1));
    add_row(scc_pkg::CMD_WRITE, 32'h8, 9'd511, 10'd0, 1,
            make_result(0, 5, 0, 0, 0, 1, 0, 1));
    add_row(scc_pkg::CMD_READ, 32'h8000_0000, 9'd256, 10'd513, 1,
            make_result(0, 6, 0, 0, 0, 1, 0, 1));
    add_row(scc_pkg::CMD_WRITE, 32'h0, 9'd0, 10'd1, 1,
            make_result(1, 0, 0, 0, 0, 0, 0, 1));
    add_row(scc_pkg::CMD_FLUSH, 32'h0, 9'd0, 10'd0, 0, none);
    add_row(scc_pkg::CMD_WRITE, 32'h7, 9'd0, 10'd512, 1,
            make_result(1, 4, 0, 0, 0, 0, 0, 1));
    // drop forgets dirty entries without writeback
    add_row(scc_pkg::CMD_DROP, 32'hFFFF_FFFF, 9'd511, 10'd1023, 1, empty_last);
    add_row(scc_pkg::CMD_FLUSH, 32'h0, 9'd0, 10'd0, 1, empty_last);
    add_row(scc_pkg::CMD_READ, 32'h7, 9'd0, 10'd0, 1,
            make_result(0, 0, 0, 0, 0, 1, 0, 1));
    add_row(scc_pkg::CMD_WRITE, 32'hAAAA_5555, 9'h155, 10'h2AA, 0, none);

    foreach (directed[i]) begin
      // typed expectation replaces the predicted one for this row
      use_typed = directed[i].typed;
      typed_override = directed[i].want;
      offer_access(directed[i].cmd, directed[i].sector, directed[i].offset,
                   directed[i].count);
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
    end
    use_typed = 0;

    // random traffic in four idling phases
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k * 4 / RANDOM_ITEMS != (k == 0 ? -1 : (k - 1) * 4 / RANDOM_ITEMS)) begin
        phase = k * 4 / RANDOM_ITEMS;
        case (phase)
          0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
          1: begin
            sender_idle_pct = 63; receiver_stall_pct = 0;
            // long receiver hold while the sender keeps offering
            long_hold_req = 1'b1;
          end
          2: begin
            // sender pause until everything in flight has come back
            drain_results();
            sender_idle_pct = 0; receiver_stall_pct = 63;
          end
          default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
        endcase
      end
      r = $urandom_range(999);
      if (r < 470) cmd = scc_pkg::CMD_READ;
      else if (r < 920) cmd = scc_pkg::CMD_WRITE;
      else if (r < 996) cmd = scc_pkg::CMD_FLUSH;
      else cmd = scc_pkg::CMD_DROP;
      offer_access(cmd, pick_sector(),
                   ($urandom_range(2) == 0) ? 9'($urandom) : 9'd0,
                   ($urandom_range(2) == 0) ? 10'($urandom) : 10'($urandom_range(513, 500)));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_results.size() != 0) @(posedge clk);
    // then keep the clock running for anything stray
    repeat (4 * NSLOT) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
